// ===== rtl/lsh_pkg.sv =====
package lsh_pkg;

    localparam int SCORE_W    = 12;
    localparam int SUM_W      = 13;
    localparam int SHIFT_W    = 4;
    localparam int DIFF_W     = 15;
    localparam int BIN_OUT_W  = 5;
    localparam int RPT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_EDGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_EDGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_SHIFT    = 3'd3;

    localparam logic signed [SCORE_W-1:0] SINGLE_EDGE_RST  = -12'sd144;
    localparam logic [SHIFT_W-1:0]        SINGLE_SHIFT_RST = 4'd4;
    localparam logic signed [SUM_W-1:0]   SUM_EDGE_RST     = -13'sd288;
    localparam logic [SHIFT_W-1:0]        SUM_SHIFT_RST    = 4'd5;

    typedef struct packed {
        logic signed [SCORE_W-1:0] single_edge;
        logic [SHIFT_W-1:0]        single_shift;
        logic signed [SUM_W-1:0]   sum_edge;
        logic [SHIFT_W-1:0]        sum_shift;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_status;

endpackage

// ===== rtl/lsh_ifs.sv =====
interface lsh_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lsh_pkg::SCORE_W-1:0]  prefix_score;
    logic signed [lsh_pkg::SCORE_W-1:0]  suffix_score;
    logic                                prefix_peak;
    logic                                suffix_peak;

    modport source (output valid, prefix_score, suffix_score, prefix_peak, suffix_peak,
                    input ready);
    modport sink   (input valid, prefix_score, suffix_score, prefix_peak, suffix_peak,
                    output ready);
endinterface

interface lsh_out_if;
    logic                              valid;
    logic                              ready;
    logic [lsh_pkg::BIN_OUT_W-1:0]     prefix_bin;
    logic [lsh_pkg::BIN_OUT_W-1:0]     suffix_bin;
    logic [lsh_pkg::BIN_OUT_W-1:0]     sum_bin;
    logic                              sum_label;
    logic [lsh_pkg::RPT_W-1:0]         prefix_count;
    logic [lsh_pkg::RPT_W-1:0]         suffix_count;
    logic [lsh_pkg::RPT_W-1:0]         sum_count;
    logic [lsh_pkg::RPT_W-1:0]         sample_total;

    modport source (output valid, prefix_bin, suffix_bin, sum_bin, sum_label,
                    prefix_count, suffix_count, sum_count, sample_total,
                    input ready);
    modport sink   (input valid, prefix_bin, suffix_bin, sum_bin, sum_label,
                    prefix_count, suffix_count, sum_count, sample_total,
                    output ready);
endinterface

interface lsh_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lsh_pkg::CFG_IDX_W-1:0]      index;
    logic [lsh_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lsh_front.sv =====
module lsh_front import lsh_pkg::*; #(
    parameter int NUM_BINS = 29,
    parameter int BIN_W    = 5,
    parameter int ADDR_W   = 6,
    parameter int ITEM_W   = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_status           i_status,
    lsh_in_if.sink            i_in,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [ITEM_W-1:0] o_item
);

    logic              r_vld;
    logic [ITEM_W-1:0] r_item;
    logic [ITEM_W-1:0] n_item;
    logic              take;

    logic signed [DIFF_W-1:0] p_diff, s_diff, u_diff;
    logic [BIN_W-1:0]         p_bin, s_bin, u_bin;
    logic [ADDR_W-1:0]        p_addr, s_addr, u_addr;
    logic                     u_lbl;

    function automatic logic [BIN_W-1:0] bin_of(input logic signed [DIFF_W-1:0] diff,
                                                input logic [SHIFT_W-1:0] sh);
        logic [DIFF_W-1:0] idx;
        idx = DIFF_W'(diff[DIFF_W-2:0] >> sh) + DIFF_W'(1);
        if (diff < 0) begin
            bin_of = '0;
        end else if (idx > DIFF_W'(NUM_BINS - 1)) begin
            bin_of = BIN_W'(NUM_BINS - 1);
        end else begin
            bin_of = BIN_W'(idx);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic lbl, input logic [BIN_W-1:0] b);
        addr_of = lbl ? ADDR_W'(NUM_BINS) + ADDR_W'(b) : ADDR_W'(b);
    endfunction

    always_comb begin
        p_diff = DIFF_W'(i_in.prefix_score) - DIFF_W'(i_cfg.single_edge);
        s_diff = DIFF_W'(i_in.suffix_score) - DIFF_W'(i_cfg.single_edge);
        u_diff = DIFF_W'(i_in.prefix_score) + DIFF_W'(i_in.suffix_score)
                 - DIFF_W'(i_cfg.sum_edge);
        p_bin  = bin_of(p_diff, i_cfg.single_shift);
        s_bin  = bin_of(s_diff, i_cfg.single_shift);
        u_bin  = bin_of(u_diff, i_cfg.sum_shift);
        u_lbl  = i_in.prefix_peak | i_in.suffix_peak;
        p_addr = addr_of(i_in.prefix_peak, p_bin);
        s_addr = addr_of(i_in.suffix_peak, s_bin);
        u_addr = addr_of(u_lbl, u_bin);
        n_item = {p_addr, s_addr, u_addr, p_bin, s_bin, u_bin, u_lbl};
    end

    assign i_in.ready = !i_status.clearing && (!r_vld || i_rdy);
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== rtl/lsh_queue.sv =====
module lsh_queue import lsh_pkg::*; #(
    parameter int W = 34
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    output logic         o_rdy,
    input  logic [W-1:0] i_data,
    output logic         o_vld,
    input  logic         i_rdy,
    output logic [W-1:0] o_data
);

    logic [W-1:0]      r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;
    logic              push, pop;

    assign o_rdy  = r_cnt != (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_vld  = r_cnt != '0;
    assign push   = i_vld && o_rdy;
    assign pop    = o_vld && i_rdy;
    assign o_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/lsh_back.sv =====
module lsh_back import lsh_pkg::*; #(
    parameter int NUM_BINS    = 29,
    parameter int COUNT_WIDTH = 32,
    parameter int BIN_W       = 5,
    parameter int ADDR_W      = 6,
    parameter int ITEM_W      = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [ITEM_W-1:0] i_item,
    output t_status           o_status,
    lsh_out_if.source         o_out
);

    localparam int DEPTH = 2 * NUM_BINS;

    logic [COUNT_WIDTH-1:0] mem_p [DEPTH];
    logic [COUNT_WIDTH-1:0] mem_s [DEPTH];
    logic [COUNT_WIDTH-1:0] mem_u [DEPTH];

    logic [ADDR_W-1:0] q_pa, q_sa, q_ua;
    logic [BIN_W-1:0]  q_pb, q_sb, q_ub;
    logic              q_lbl;

    logic [ADDR_W-1:0] r_pa, r_sa, r_ua;
    logic [BIN_W-1:0]  r_pb, r_sb, r_ub;
    logic              r_lbl;
    logic              r_rd_vld;

    logic [COUNT_WIDTH-1:0] r_pd, r_sd, r_ud;
    logic                   r_pf, r_sf, r_uf;
    logic [COUNT_WIDTH-1:0] r_pw, r_sw, r_uw;
    logic [COUNT_WIDTH-1:0] n_pc, n_sc, n_uc, n_smp;
    logic [COUNT_WIDTH-1:0] r_smp;

    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_o_vld;
    logic [BIN_OUT_W-1:0] r_o_pb, r_o_sb, r_o_ub;
    logic              r_o_lbl;
    logic [RPT_W-1:0]  r_o_pc, r_o_sc, r_o_uc, r_o_tc;

    logic              fire, issue, w_en;
    logic [ADDR_W-1:0] w_pa, w_sa, w_ua;
    logic [COUNT_WIDTH-1:0] w_pd, w_sd, w_ud;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [RPT_W-1:0] rpt(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        rpt = (w > 64'hFFFF_FFFF) ? '1 : w[RPT_W-1:0];
    endfunction

    assign {q_pa, q_sa, q_ua, q_pb, q_sb, q_ub, q_lbl} = i_item;

    assign fire  = r_rd_vld && (!r_o_vld || o_out.ready);
    assign issue = i_vld && !r_clr && (!r_rd_vld || fire);
    assign o_rdy = issue;
    assign o_status.clearing = r_clr;

    // read data is stale when the entry is written back on the same edge
    always_comb begin
        n_pc  = sat_inc(r_pf ? r_pw : r_pd);
        n_sc  = sat_inc(r_sf ? r_sw : r_sd);
        n_uc  = sat_inc(r_uf ? r_uw : r_ud);
        n_smp = sat_inc(r_smp);
        w_en  = r_clr || fire;
        w_pa  = r_clr ? r_clr_addr : r_pa;
        w_sa  = r_clr ? r_clr_addr : r_sa;
        w_ua  = r_clr ? r_clr_addr : r_ua;
        w_pd  = r_clr ? '0 : n_pc;
        w_sd  = r_clr ? '0 : n_sc;
        w_ud  = r_clr ? '0 : n_uc;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_p[w_pa] <= w_pd;
            mem_s[w_sa] <= w_sd;
            mem_u[w_ua] <= w_ud;
        end
        if (issue) begin
            r_pd <= mem_p[q_pa];
            r_sd <= mem_s[q_sa];
            r_ud <= mem_u[q_ua];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_o_vld    <= 1'b0;
            r_smp      <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (fire) begin
                r_rd_vld <= 1'b0;
            end
            if (fire) begin
                r_o_vld <= 1'b1;
                r_smp   <= n_smp;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pa  <= q_pa;
            r_sa  <= q_sa;
            r_ua  <= q_ua;
            r_pb  <= q_pb;
            r_sb  <= q_sb;
            r_ub  <= q_ub;
            r_lbl <= q_lbl;
            r_pf  <= fire && (r_pa == q_pa);
            r_sf  <= fire && (r_sa == q_sa);
            r_uf  <= fire && (r_ua == q_ua);
        end
        if (fire) begin
            r_pw    <= n_pc;
            r_sw    <= n_sc;
            r_uw    <= n_uc;
            r_o_pb  <= BIN_OUT_W'(r_pb);
            r_o_sb  <= BIN_OUT_W'(r_sb);
            r_o_ub  <= BIN_OUT_W'(r_ub);
            r_o_lbl <= r_lbl;
            r_o_pc  <= rpt(n_pc);
            r_o_sc  <= rpt(n_sc);
            r_o_uc  <= rpt(n_uc);
            r_o_tc  <= rpt(n_smp);
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.prefix_bin   = r_o_pb;
    assign o_out.suffix_bin   = r_o_sb;
    assign o_out.sum_bin      = r_o_ub;
    assign o_out.sum_label    = r_o_lbl;
    assign o_out.prefix_count = r_o_pc;
    assign o_out.suffix_count = r_o_sc;
    assign o_out.sum_count    = r_o_uc;
    assign o_out.sample_total = r_o_tc;

    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !r_rd_vld && !issue)
        else $error("histogram read during clearing pass");

    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_o_vld)
        else $error("result lost between read stage and output");

    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> r_o_tc != '0 && r_o_pc != '0 && r_o_sc != '0 && r_o_uc != '0)
        else $error("reported count is zero after an update");

endmodule

// ===== rtl/labeled_score_histogram.sv =====
// Channel  Port   Dir  Beat contents
// input    i_in   in   prefix_score, suffix_score, prefix_peak, suffix_peak
// result   o_out  out  prefix/suffix/sum bin, sum_label, three counts, sample_total
// config   i_cfg  in   index (0..3), data; always ready
//
// One beat per cycle in and out while no clearing pass runs and the output
// is not stalled. Path: bin register, queue, histogram read, output register.
// Counters update by read-modify-write on three memories with a one-deep
// forward of the entry written on the same edge.
// After reset, a clearing pass zeroes all 2*NUM_BINS entries of the memories;
// i_in.ready stays low during it. Output stalls back up through the queue.
module labeled_score_histogram import lsh_pkg::*; #(
    parameter int NUM_BINS    = 29,
    parameter int COUNT_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsh_in_if.sink    i_in,
    lsh_cfg_if.sink   i_cfg,
    lsh_out_if.source o_out
);

    localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ADDR_W = $clog2(2 * NUM_BINS);
    localparam int ITEM_W = 3 * ADDR_W + 3 * BIN_W + 1;

    t_cfg              r_cfg;
    t_status           status;
    logic              f_vld, q_rdy, q_vld, b_rdy;
    logic [ITEM_W-1:0] f_item, q_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.single_edge  <= SINGLE_EDGE_RST;
            r_cfg.single_shift <= SINGLE_SHIFT_RST;
            r_cfg.sum_edge     <= SUM_EDGE_RST;
            r_cfg.sum_shift    <= SUM_SHIFT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SINGLE_EDGE:  r_cfg.single_edge  <= i_cfg.data[SCORE_W-1:0];
                REG_SINGLE_SHIFT: r_cfg.single_shift <= i_cfg.data[SHIFT_W-1:0];
                REG_SUM_EDGE:     r_cfg.sum_edge     <= i_cfg.data[SUM_W-1:0];
                REG_SUM_SHIFT:    r_cfg.sum_shift    <= i_cfg.data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lsh_front #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W),
        .ADDR_W   (ADDR_W),
        .ITEM_W   (ITEM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_status (status),
        .i_in     (i_in),
        .o_vld    (f_vld),
        .i_rdy    (q_rdy),
        .o_item   (f_item)
    );

    lsh_queue #(
        .W (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .o_rdy   (q_rdy),
        .i_data  (f_item),
        .o_vld   (q_vld),
        .i_rdy   (b_rdy),
        .o_data  (q_item)
    );

    lsh_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .BIN_W       (BIN_W),
        .ADDR_W      (ADDR_W),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .o_rdy    (b_rdy),
        .i_item   (q_item),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule
